/* design/pig_pkg.sv */
// ----------------------------------------------------------------------------
// pig_pkg
// Shared constants and types for the periodic image gradient block.
// ----------------------------------------------------------------------------
`default_nettype none

package pig_pkg;

    // Default sizing of the top level
    localparam int DEF_MAX_ROWS    = 1024;
    localparam int DEF_MAX_COLS    = 1024;
    localparam int DEF_MAX_CHAN    = 4;
    localparam int DEF_SAMPLE_BITS = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int ROWS_REG_W = 11;
    localparam int COLS_REG_W = 11;
    localparam int CHAN_REG_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS   = 2'd2;

    localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 11'd1024;
    localparam logic [COLS_REG_W-1:0] COLS_RESET = 11'd1024;
    localparam logic [CHAN_REG_W-1:0] CHAN_RESET = 3'd1;

    // Result fields
    localparam int OUT_POS_W  = 10;
    localparam int OUT_CHAN_W = 2;

    localparam logic DIR_HORZ = 1'b0;
    localparam logic DIR_VERT = 1'b1;

    // Bit positions of the pending-result mask, in emission order
    localparam int NUM_RES     = 4;
    localparam int BIT_DX_LEFT = 0;
    localparam int BIT_DX_WRAP = 1;
    localparam int BIT_DY_UP   = 2;
    localparam int BIT_DY_WRAP = 3;

    // Position flags of the sample being accepted
    typedef struct packed {
        logic dx_left;   // column above zero: difference of the left neighbor
        logic dx_wrap;   // last column: wrap to the first column
        logic dy_up;     // row above zero: difference of the pixel above
        logic dy_wrap;   // last row: wrap to the first row
        logic row_zero;  // first row: the sample is its own first-row value
    } t_flags;

endpackage

`default_nettype wire

/* design/pig_mem.sv */
// ----------------------------------------------------------------------------
// pig_mem
// Single-port sample memory, read before write, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pig_mem #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rd_en,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Old contents come out when read and write hit the same entry
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_addr];
        end
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

/* design/pig_ctrl.sv */
// ----------------------------------------------------------------------------
// pig_ctrl
// Configuration registers, raster position counters, store addressing and
// the per-channel first and previous samples of the current row.
// ----------------------------------------------------------------------------
`default_nettype none

module pig_ctrl #(
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_COLS    = 1024,
    parameter int MAX_CHAN    = 4,
    parameter int SAMPLE_BITS = 16,
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int CH_W   = (MAX_CHAN > 1) ? $clog2(MAX_CHAN) : 1,
    localparam int DEPTH  = MAX_COLS * MAX_CHAN,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [pig_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [pig_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                              i_fire,
    input  wire logic signed [SAMPLE_BITS-1:0]     i_pixel_value,
    output logic      [ROW_W-1:0]                  o_row,
    output logic      [COL_W-1:0]                  o_col,
    output logic      [CH_W-1:0]                   o_chan,
    output logic      [ADDR_W-1:0]                 o_addr,
    output pig_pkg::t_flags                        o_flags,
    output logic signed [SAMPLE_BITS-1:0]          o_first_px,
    output logic signed [SAMPLE_BITS-1:0]          o_prev_px
);

    import pig_pkg::*;

    localparam int POS_W  = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int CMP_W  = ((POS_W > ROWS_REG_W) ? POS_W : ROWS_REG_W) + 2;
    localparam int CHC_W  = ((CH_W > CHAN_REG_W) ? CH_W : CHAN_REG_W) + 2;
    localparam int PROD_W = COL_W + CHC_W + 1;

    logic [ROWS_REG_W-1:0] r_rows;
    logic [COLS_REG_W-1:0] r_cols;
    logic [CHAN_REG_W-1:0] r_chan_cfg;

    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [CH_W-1:0]  r_k,   n_k;

    logic signed [SAMPLE_BITS-1:0] r_row_first [MAX_CHAN];
    logic signed [SAMPLE_BITS-1:0] r_prev_col  [MAX_CHAN];

    logic [CMP_W-1:0]  rows_x, cols_x, rows_eff, cols_eff;
    logic [CHC_W-1:0]  chn_x, chn_eff;
    logic              chan_last, col_last, row_last;
    logic [PROD_W-1:0] addr_w;

    // Zero acts as one, anything above the maximum acts as the maximum
    always_comb begin
        rows_x = CMP_W'(r_rows);
        cols_x = CMP_W'(r_cols);
        chn_x  = CHC_W'(r_chan_cfg);

        if (rows_x == '0) begin
            rows_eff = CMP_W'(1);
        end else if (rows_x > CMP_W'(MAX_ROWS)) begin
            rows_eff = CMP_W'(MAX_ROWS);
        end else begin
            rows_eff = rows_x;
        end

        if (cols_x == '0) begin
            cols_eff = CMP_W'(1);
        end else if (cols_x > CMP_W'(MAX_COLS)) begin
            cols_eff = CMP_W'(MAX_COLS);
        end else begin
            cols_eff = cols_x;
        end

        if (chn_x == '0) begin
            chn_eff = CHC_W'(1);
        end else if (chn_x > CHC_W'(MAX_CHAN)) begin
            chn_eff = CHC_W'(MAX_CHAN);
        end else begin
            chn_eff = chn_x;
        end
    end

    assign chan_last = (CHC_W'(r_k) + CHC_W'(1)) >= chn_eff;
    assign col_last  = (CMP_W'(r_col) + CMP_W'(1)) >= cols_eff;
    assign row_last  = (CMP_W'(r_row) + CMP_W'(1)) >= rows_eff;

    assign addr_w = PROD_W'(r_col) * PROD_W'(chn_eff) + PROD_W'(r_k);

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        n_k   = r_k;
        if (chan_last) begin
            n_k = '0;
            if (col_last) begin
                n_col = '0;
                n_row = row_last ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end else begin
            n_k = r_k + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows     <= ROWS_RESET;
            r_cols     <= COLS_RESET;
            r_chan_cfg <= CHAN_RESET;
            r_row      <= '0;
            r_col      <= '0;
            r_k        <= '0;
        end else if (i_cfg_we) begin
            // Any write restarts the image
            case (i_cfg_index)
                REG_IMAGE_ROWS: r_rows     <= i_cfg_data[ROWS_REG_W-1:0];
                REG_IMAGE_COLS: r_cols     <= i_cfg_data[COLS_REG_W-1:0];
                REG_CHANNELS:   r_chan_cfg <= i_cfg_data[CHAN_REG_W-1:0];
                default: ;
            endcase
            r_row <= '0;
            r_col <= '0;
            r_k   <= '0;
        end else if (i_fire) begin
            r_row <= n_row;
            r_col <= n_col;
            r_k   <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            if (r_col == '0) begin
                r_row_first[r_k] <= i_pixel_value;
            end
            r_prev_col[r_k] <= i_pixel_value;
        end
    end

    assign o_row  = r_row;
    assign o_col  = r_col;
    assign o_chan = r_k;
    assign o_addr = addr_w[ADDR_W-1:0];

    assign o_flags.dx_left  = (r_col != '0);
    assign o_flags.dx_wrap  = col_last;
    assign o_flags.dy_up    = (r_row != '0);
    assign o_flags.dy_wrap  = row_last;
    assign o_flags.row_zero = (r_row == '0);

    // A single column wraps onto the sample itself
    assign o_first_px = (r_col == '0) ? i_pixel_value : r_row_first[r_k];
    assign o_prev_px  = r_prev_col[r_k];

endmodule

`default_nettype wire

/* design/pig_emit.sv */
// ----------------------------------------------------------------------------
// pig_emit
// Holds one accepted sample with its operands, forms its differences and
// hands them out through the result register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module pig_emit #(
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_COLS    = 1024,
    parameter int MAX_CHAN    = 4,
    parameter int SAMPLE_BITS = 16,
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int CH_W  = (MAX_CHAN > 1) ? $clog2(MAX_CHAN) : 1,
    localparam int DW    = SAMPLE_BITS + 1
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_load,
    input  wire logic [ROW_W-1:0]                   i_row,
    input  wire logic [COL_W-1:0]                   i_col,
    input  wire logic [CH_W-1:0]                    i_chan,
    input  wire pig_pkg::t_flags                    i_flags,
    input  wire logic signed [SAMPLE_BITS-1:0]      i_pixel,
    input  wire logic signed [SAMPLE_BITS-1:0]      i_first_px,
    input  wire logic signed [SAMPLE_BITS-1:0]      i_prev_px,
    input  wire logic signed [SAMPLE_BITS-1:0]      i_above_px,
    input  wire logic signed [SAMPLE_BITS-1:0]      i_top_px,
    input  wire logic                               i_out_ready,
    output logic                                    o_stage_free,
    output logic                                    o_out_valid,
    output logic                                    o_direction,
    output logic [pig_pkg::OUT_POS_W-1:0]           o_out_row,
    output logic [pig_pkg::OUT_POS_W-1:0]           o_out_col,
    output logic [pig_pkg::OUT_CHAN_W-1:0]          o_out_channel,
    output logic signed [DW-1:0]                    o_diff_value,
    output logic                                    o_last_of_item
);

    import pig_pkg::*;

    logic                          r_a_valid;
    logic [NUM_RES-1:0]            r_a_mask;
    logic [ROW_W-1:0]              r_a_row;
    logic [COL_W-1:0]              r_a_col;
    logic [CH_W-1:0]               r_a_chan;
    logic                          r_a_row_zero;
    logic signed [SAMPLE_BITS-1:0] r_a_pixel, r_a_first, r_a_prev;

    logic [NUM_RES-1:0] new_mask, pick, rest;
    logic               out_load, take, a_done;

    logic signed [DW-1:0] v_x, prev_x, first_x, above_x, top_x;
    logic signed [DW-1:0] sel_diff;
    logic                 sel_dir;
    logic [ROW_W-1:0]     sel_row;
    logic [COL_W-1:0]     sel_col;
    logic [31:0]          row_w, col_w, chan_w;

    always_comb begin
        new_mask              = '0;
        new_mask[BIT_DX_LEFT] = i_flags.dx_left;
        new_mask[BIT_DX_WRAP] = i_flags.dx_wrap;
        new_mask[BIT_DY_UP]   = i_flags.dy_up;
        new_mask[BIT_DY_WRAP] = i_flags.dy_wrap;
    end

    // Lowest pending result goes first
    assign pick = r_a_mask & (~r_a_mask + 1'b1);
    assign rest = r_a_mask & ~pick;

    assign out_load     = !o_out_valid || i_out_ready;
    assign take         = r_a_valid && out_load && (r_a_mask != '0);
    assign a_done       = r_a_valid && ((r_a_mask == '0) || (out_load && (rest == '0)));
    assign o_stage_free = !r_a_valid || a_done;

    assign v_x     = {r_a_pixel[SAMPLE_BITS-1], r_a_pixel};
    assign prev_x  = {r_a_prev[SAMPLE_BITS-1], r_a_prev};
    assign first_x = {r_a_first[SAMPLE_BITS-1], r_a_first};
    assign above_x = {i_above_px[SAMPLE_BITS-1], i_above_px};
    // On the first row the wrapping neighbor is the sample just taken
    assign top_x   = r_a_row_zero ? v_x : {i_top_px[SAMPLE_BITS-1], i_top_px};

    always_comb begin
        sel_dir  = DIR_HORZ;
        sel_row  = r_a_row;
        sel_col  = r_a_col;
        sel_diff = '0;
        case (pick)
            NUM_RES'(1) << BIT_DX_LEFT: begin
                sel_col  = r_a_col - 1'b1;
                sel_diff = v_x - prev_x;
            end
            NUM_RES'(1) << BIT_DX_WRAP: begin
                sel_diff = first_x - v_x;
            end
            NUM_RES'(1) << BIT_DY_UP: begin
                sel_dir  = DIR_VERT;
                sel_row  = r_a_row - 1'b1;
                sel_diff = v_x - above_x;
            end
            NUM_RES'(1) << BIT_DY_WRAP: begin
                sel_dir  = DIR_VERT;
                sel_diff = top_x - v_x;
            end
            default: ;
        endcase
        row_w  = 32'(sel_row);
        col_w  = 32'(sel_col);
        chan_w = 32'(r_a_chan);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_a_mask  <= '0;
        end else if (i_load) begin
            r_a_valid <= 1'b1;
            r_a_mask  <= new_mask;
        end else if (a_done) begin
            r_a_valid <= 1'b0;
            r_a_mask  <= '0;
        end else if (take) begin
            r_a_mask <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a_row      <= i_row;
            r_a_col      <= i_col;
            r_a_chan     <= i_chan;
            r_a_row_zero <= i_flags.row_zero;
            r_a_pixel    <= i_pixel;
            r_a_first    <= i_first_px;
            r_a_prev     <= i_prev_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (out_load) begin
            o_out_valid <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            o_direction    <= sel_dir;
            o_out_row      <= row_w[OUT_POS_W-1:0];
            o_out_col      <= col_w[OUT_POS_W-1:0];
            o_out_channel  <= chan_w[OUT_CHAN_W-1:0];
            o_diff_value   <= sel_diff;
            o_last_of_item <= (rest == '0);
        end
    end

`ifndef NO_ASSERTIONS
    a_idle_mask_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_a_valid |-> (r_a_mask == '0))
        else $error("pending results without a held sample");

    a_pick_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(pick))
        else $error("more than one result selected");

    a_load_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!r_a_valid || a_done))
        else $error("new sample overwrites pending results");

    a_take_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> o_out_valid)
        else $error("result taken but not presented");
`endif

endmodule

`default_nettype wire

/* design/periodic_image_gradient_top.sv */
// ----------------------------------------------------------------------------
// periodic_image_gradient_top
// Streaming forward-difference gradient of a raster image on a torus.
// ----------------------------------------------------------------------------
// Samples enter in raster order with channels interleaved; each accepted
// sample produces zero to four differences (left-neighbor dx, wrapping dx at
// the last column, dy of the pixel above, wrapping dy at the last row), each
// delivered as one result on the single output port, the last one flagged.
// The port carries one result a cycle while i_out_ready allows; an interior
// pixel gives two, and a new sample enters as the held one's last is taken.
// The previous and first rows sit in two single-port memories of MAX_COLS *
// MAX_CHAN samples, read and written at acceptance, the first-row one only
// on row 0. Any configuration write restarts the image at row 0.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_image_gradient_top #(
    parameter int MAX_ROWS    = pig_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS    = pig_pkg::DEF_MAX_COLS,
    parameter int MAX_CHAN    = pig_pkg::DEF_MAX_CHAN,
    parameter int SAMPLE_BITS = pig_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [pig_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [pig_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]      i_pixel_value,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic                                    o_direction,
    output logic [pig_pkg::OUT_POS_W-1:0]           o_out_row,
    output logic [pig_pkg::OUT_POS_W-1:0]           o_out_col,
    output logic [pig_pkg::OUT_CHAN_W-1:0]          o_out_channel,
    output logic signed [SAMPLE_BITS:0]             o_diff_value,
    output logic                                    o_last_of_item
);

    import pig_pkg::*;

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CH_W   = (MAX_CHAN > 1) ? $clog2(MAX_CHAN) : 1;
    localparam int DEPTH  = MAX_COLS * MAX_CHAN;
    localparam int ADDR_W = $clog2(DEPTH);

    logic                          fire, stage_free;
    logic [ROW_W-1:0]              cur_row;
    logic [COL_W-1:0]              cur_col;
    logic [CH_W-1:0]               cur_chan;
    logic [ADDR_W-1:0]             cur_addr;
    t_flags                        cur_flags;
    logic signed [SAMPLE_BITS-1:0] first_px, prev_px, above_px, top_px;

    assign o_in_ready = stage_free;
    assign fire       = i_in_valid && stage_free;

    pig_ctrl #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .MAX_CHAN    (MAX_CHAN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_fire        (fire),
        .i_pixel_value (i_pixel_value),
        .o_row         (cur_row),
        .o_col         (cur_col),
        .o_chan        (cur_chan),
        .o_addr        (cur_addr),
        .o_flags       (cur_flags),
        .o_first_px    (first_px),
        .o_prev_px     (prev_px)
    );

    pig_mem #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_prev_row (
        .i_clk     (i_clk),
        .i_rd_en   (fire),
        .i_wr_en   (fire),
        .i_addr    (cur_addr),
        .i_wr_data (i_pixel_value),
        .o_rd_data (above_px)
    );

    pig_mem #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_first_row (
        .i_clk     (i_clk),
        .i_rd_en   (fire),
        .i_wr_en   (fire && cur_flags.row_zero),
        .i_addr    (cur_addr),
        .i_wr_data (i_pixel_value),
        .o_rd_data (top_px)
    );

    pig_emit #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .MAX_CHAN    (MAX_CHAN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (fire),
        .i_row          (cur_row),
        .i_col          (cur_col),
        .i_chan         (cur_chan),
        .i_flags        (cur_flags),
        .i_pixel        (i_pixel_value),
        .i_first_px     (first_px),
        .i_prev_px      (prev_px),
        .i_above_px     (above_px),
        .i_top_px       (top_px),
        .i_out_ready    (i_out_ready),
        .o_stage_free   (stage_free),
        .o_out_valid    (o_out_valid),
        .o_direction    (o_direction),
        .o_out_row      (o_out_row),
        .o_out_col      (o_out_col),
        .o_out_channel  (o_out_channel),
        .o_diff_value   (o_diff_value),
        .o_last_of_item (o_last_of_item)
    );

endmodule

`default_nettype wire
